// File: src/rse_pkg.sv
// Package: shared types, constants and codes for the resizing stack engine.
`timescale 1ns / 1ps

package rse_pkg;

    // Storage geometry
    localparam int MAX_DEPTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_DEPTH);
    localparam int CNT_W     = 11;

    // Capacity floor applied to configuration writes
    localparam int MIN_CAP_FLOOR = 10;

    // floor(x/5) as (x * RECIP5) >> RECIP_SH, exact for x below 4200
    localparam int RECIP_SH = 16;
    localparam int RECIP5   = 13108;
    localparam int PROD_W   = 30;

    // Command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Status codes
    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_PUSH_FULL = 2'd1;
    localparam logic [1:0] STAT_POP_EMPTY = 2'd2;

    // Request payload
    typedef struct packed {
        logic               cmd;
        logic signed [31:0] value;
    } t_req;

    // Result payload
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] popped_value;
        logic [CNT_W-1:0]   depth;
        logic [CNT_W-1:0]   capacity;
        logic [CNT_W-1:0]   largest_capacity;
    } t_res;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_RESIZE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;
        logic resize;
        logic cfg_we;
    } t_dp_cmd;

endpackage

// File: src/rse_ctrl.sv
// Controller: sequences one request through execute and resize steps.
`timescale 1ns / 1ps

module rse_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_cfg_valid,
    output logic             busy,
    output logic             o_cfg_ready,
    output logic             o_res_valid,
    output rse_pkg::t_dp_cmd o_cmd
);
    import rse_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_valid;

    // State register and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_RESIZE);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_RESIZE;
            end
            ST_RESIZE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        busy         = 1'b0;
        o_cfg_ready  = 1'b0;
        o_cmd        = '0;
        case (r_state)
            ST_IDLE: begin
                o_cfg_ready  = 1'b1;
                o_cmd.exec   = start;
                o_cmd.cfg_we = i_cfg_valid;
            end
            ST_RESIZE: begin
                busy         = 1'b1;
                o_cmd.resize = 1'b1;
            end
            default: busy = 1'b1;
        endcase
    end

    assign o_res_valid = r_valid;

endmodule

// File: src/rse_dp.sv
// Datapath: stack memory, entry count, capacity tracking and result register.
`timescale 1ns / 1ps

module rse_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rse_pkg::t_dp_cmd          i_cmd,
    input  rse_pkg::t_req             i_req,
    input  logic [rse_pkg::CNT_W-1:0] i_cfg_data,
    output rse_pkg::t_res             o_res
);
    import rse_pkg::*;

    localparam logic [CNT_W-1:0]  DEPTH_MAX = CNT_W'(MAX_DEPTH);
    localparam logic [CNT_W-1:0]  CAP_FLOOR = CNT_W'(MIN_CAP_FLOOR);
    localparam logic [PROD_W-1:0] RECIP     = PROD_W'(RECIP5);

    logic signed [31:0] r_mem [MAX_DEPTH];
    logic signed [31:0] r_rdata;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] r_peak;
    logic [CNT_W-1:0] r_min_cap;
    logic [1:0]       r_status;
    logic             r_pop_ok;
    t_res             r_res;

    logic [CNT_W-1:0] n_cap;
    logic [CNT_W-1:0] n_peak;
    logic [CNT_W-1:0] cfg_clamped;
    logic [CNT_W-1:0] count_dec;
    logic             push_full;
    logic             pop_empty;
    logic             do_push;
    logic             do_pop;
    logic [PROD_W-1:0] prod_grow;
    logic [PROD_W-1:0] prod_shrink;
    logic [CNT_W-1:0]  thr_grow;
    logic [CNT_W-1:0]  thr_shrink;
    logic [CNT_W:0]    grown;

    // Request decode
    assign count_dec = r_count - CNT_W'(1);
    assign push_full = (r_count >= r_cap) || (r_count >= DEPTH_MAX);
    assign pop_empty = (r_count == '0);
    assign do_push   = i_cmd.exec && (i_req.cmd == CMD_PUSH) && !push_full;
    assign do_pop    = i_cmd.exec && (i_req.cmd == CMD_POP) && !pop_empty;

    // Configuration clamp into [floor, MAX_DEPTH]
    always_comb begin
        if (i_cfg_data < CAP_FLOOR)      cfg_clamped = CAP_FLOOR;
        else if (i_cfg_data > DEPTH_MAX) cfg_clamped = DEPTH_MAX;
        else                             cfg_clamped = i_cfg_data;
    end

    // Stack memory: one write or one registered read per request
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_count[ADDR_W-1:0]] <= i_req.value;
        if (do_pop)  r_rdata <= r_mem[count_dec[ADDR_W-1:0]];
    end

    // Resize thresholds: floor(cap*4/5) and floor(cap/5) by reciprocal
    assign prod_grow   = (PROD_W'(r_cap) << 2) * RECIP;
    assign prod_shrink = PROD_W'(r_cap) * RECIP;
    assign thr_grow    = prod_grow[RECIP_SH +: CNT_W];
    assign thr_shrink  = prod_shrink[RECIP_SH +: CNT_W];
    assign grown       = {1'b0, r_cap} + {2'b00, r_cap[CNT_W-1:1]};

    // New capacity and peak
    always_comb begin
        n_cap  = r_cap;
        n_peak = r_peak;
        if (r_count >= thr_grow) begin
            n_cap = (grown > {1'b0, DEPTH_MAX}) ? DEPTH_MAX : grown[CNT_W-1:0];
            if (n_cap > r_peak) n_peak = n_cap;
        end else if ((r_count <= thr_shrink) && (r_cap > r_min_cap)) begin
            n_cap = {1'b0, r_cap[CNT_W-1:1]};
        end
    end

    // Control state: count, capacity, peak, floor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cap     <= CAP_FLOOR;
            r_peak    <= CAP_FLOOR;
            r_min_cap <= CAP_FLOOR;
        end else begin
            if (i_cmd.cfg_we) begin
                r_min_cap <= cfg_clamped;
                if (pop_empty) begin
                    r_cap  <= cfg_clamped;
                    r_peak <= cfg_clamped;
                end
            end
            if (do_push)      r_count <= r_count + CNT_W'(1);
            else if (do_pop)  r_count <= count_dec;
            if (i_cmd.resize) begin
                r_cap  <= n_cap;
                r_peak <= n_peak;
            end
        end
    end

    // Per-request status held for the resize step
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_pop_ok <= do_pop;
            if (i_req.cmd == CMD_PUSH) r_status <= push_full ? STAT_PUSH_FULL : STAT_DONE;
            else                       r_status <= pop_empty ? STAT_POP_EMPTY : STAT_DONE;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.resize) begin
            r_res.status           <= r_status;
            r_res.popped_value     <= r_pop_ok ? r_rdata : 32'sd0;
            r_res.depth            <= r_count;
            r_res.capacity         <= n_cap;
            r_res.largest_capacity <= n_peak;
        end
    end

    assign o_res = r_res;

endmodule

// File: src/resizing_stack_engine_core.sv
// Top level: resizing stack engine, controller plus datapath.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+-----------------------------
//  request  | in        | start high, busy low       | i_req  (cmd, value)
//  result   | out       | o_res_valid, one cycle     | o_res  (status .. largest)
//  config   | in        | i_cfg_valid & o_cfg_ready  | i_cfg_data (min_capacity)
//
// A request runs an execute step and then a resize step: the accept edge does
// the memory write or read and the count update, the next edge runs the resize
// check and loads the result. The result strobe is high in the cycle after
// that, while a new request may already be taken; none is accepted during the
// resize step, while busy is high. Reset is synchronous, active low; the stack
// memory is not cleared. The receiver cannot stall the result.
`timescale 1ns / 1ps

module resizing_stack_engine_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  rse_pkg::t_req             i_req,
    output logic                      o_res_valid,
    output rse_pkg::t_res             o_res,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [rse_pkg::CNT_W-1:0] i_cfg_data
);
    import rse_pkg::*;

    t_dp_cmd dp_cmd;

    // Sequencer
    rse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cfg_valid (i_cfg_valid),
        .busy        (busy),
        .o_cfg_ready (o_cfg_ready),
        .o_res_valid (o_res_valid),
        .o_cmd       (dp_cmd)
    );

    // Stack and capacity datapath
    rse_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_req      (i_req),
        .i_cfg_data (i_cfg_data),
        .o_res      (o_res)
    );

endmodule

// File: src/rse_checker.sv
// Checker: port-level properties of the resizing stack engine, bound to the top.
`timescale 1ns / 1ps

module rse_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_res_valid,
    input rse_pkg::t_res o_res
);
    import rse_pkg::*;

    // An accepted request blocks the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted request");

    // Every accepted request yields a result strobe
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_res_valid)
        else $error("result strobe missing after request");

    // Depth never exceeds capacity, capacity never exceeds peak
    a_depth_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.depth <= o_res.capacity) &&
                        (o_res.capacity <= o_res.largest_capacity))
        else $error("depth or capacity out of order");

    // Empty pop reports zero data and zero depth
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status == STAT_POP_EMPTY)) |->
            (o_res.popped_value == 32'sd0) && (o_res.depth == '0))
        else $error("empty pop result inconsistent");

endmodule

bind resizing_stack_engine_core rse_checker u_rse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

// File: tb/testbench.sv
// Self-checking testbench for the resizing stack engine: random and directed push/pop traffic.
`timescale 1ns / 1ps

module testbench;
    import rse_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;

    typedef enum logic {
        ENT_REQ,
        ENT_CFG
    } t_entry_kind;

    // One line of stimulus: a stack request or a min_capacity write
    typedef struct {
        t_entry_kind      kind;
        t_req             req;
        logic [CNT_W-1:0] cfg;
        int               idle_pct;
    } t_stack_entry;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_req             i_req       = '0;
    logic             o_res_valid;
    t_res             o_res;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data  = '0;

    t_stack_entry     cmd_backlog[$];
    t_res             pending_results[$];
    int               err_count = 0;
    int               quiet_cycles = 0;

    // Shadow copy of the stack and its capacity bookkeeping
    logic signed [31:0] stack_words [MAX_DEPTH];
    int                 word_count = 0;
    int                 cap_now    = MIN_CAP_FLOOR;
    int                 cap_peak   = MIN_CAP_FLOOR;
    int                 cap_floor  = MIN_CAP_FLOOR;

    resizing_stack_engine_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    // Apply one push/pop to the shadow stack, then the grow/shrink check
    function automatic t_res apply_stack_cmd(t_req req);
        t_res res;
        int   grown;
        res        = '0;
        res.status = STAT_DONE;
        if (req.cmd == CMD_PUSH) begin
            if (word_count >= cap_now || word_count >= MAX_DEPTH) begin
                res.status = STAT_PUSH_FULL;
            end else begin
                stack_words[word_count] = req.value;
                word_count++;
            end
        end else if (word_count == 0) begin
            res.status = STAT_POP_EMPTY;
        end else begin
            word_count--;
            res.popped_value = stack_words[word_count];
        end
        if (word_count >= (cap_now * 4) / 5) begin
            grown   = (cap_now * 3) / 2;
            cap_now = (grown > MAX_DEPTH) ? MAX_DEPTH : grown;
            if (cap_now > cap_peak) cap_peak = cap_now;
        end else if (word_count <= cap_now / 5 && cap_now > cap_floor) begin
            cap_now = cap_now / 2;
        end
        res.depth            = CNT_W'(word_count);
        res.capacity         = CNT_W'(cap_now);
        res.largest_capacity = CNT_W'(cap_peak);
        return res;
    endfunction

    // min_capacity write: clamp, and reload capacity only on an empty stack
    function automatic void load_floor(logic [CNT_W-1:0] data);
        if (data < MIN_CAP_FLOOR)  cap_floor = MIN_CAP_FLOOR;
        else if (data > MAX_DEPTH) cap_floor = MAX_DEPTH;
        else                       cap_floor = int'(data);
        if (word_count == 0) begin
            cap_now  = cap_floor;
            cap_peak = cap_floor;
        end
    endfunction

    task automatic queue_req(logic cmd, logic signed [31:0] value, int idle_pct);
        t_stack_entry ent;
        ent.kind      = ENT_REQ;
        ent.req.cmd   = cmd;
        ent.req.value = value;
        ent.cfg       = '0;
        ent.idle_pct  = idle_pct;
        cmd_backlog.push_back(ent);
    endtask

    task automatic queue_cfg(logic [CNT_W-1:0] data);
        t_stack_entry ent;
        ent.kind     = ENT_CFG;
        ent.req      = '0;
        ent.cfg      = data;
        ent.idle_pct = 0;
        cmd_backlog.push_back(ent);
    endtask

    task automatic queue_random_run(int count, int pop_pct, int idle_pct);
        for (int k = 0; k < count; k++) begin
            queue_req(($urandom_range(0, 99) < pop_pct) ? CMD_POP : CMD_PUSH,
                      $urandom, idle_pct);
        end
    endtask

    // Driver: presents the next backlog entry, holding it until taken
    always @(posedge i_clk) begin : drive
        logic         req_taken;
        logic         cfg_taken;
        t_stack_entry ent;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            req_taken = start && !busy;
            cfg_taken = i_cfg_valid && o_cfg_ready;
            if (req_taken) pending_results.push_back(apply_stack_cmd(i_req));
            if (cfg_taken) load_floor(i_cfg_data);

            if ((start && !req_taken) || (i_cfg_valid && !cfg_taken)) begin
                // request still waiting for its handshake
            end else if (cmd_backlog.size() != 0 && cmd_backlog[0].kind == ENT_CFG) begin
                // register writes only once every result is back
                start <= 1'b0;
                if (pending_results.size() == 0) begin
                    ent = cmd_backlog.pop_front();
                    i_cfg_data  <= ent.cfg;
                    i_cfg_valid <= 1'b1;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end else if (cmd_backlog.size() != 0 &&
                         $urandom_range(0, 99) >= cmd_backlog[0].idle_pct) begin
                ent = cmd_backlog.pop_front();
                i_req       <= ent.req;
                start       <= 1'b1;
                i_cfg_valid <= 1'b0;
            end else begin
                start       <= 1'b0;
                i_cfg_valid <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result against the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_res want;
        if (i_rst_n && o_res_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: %p", o_res));
            end else begin
                want = pending_results.pop_front();
                if (o_res.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_res.status, want.status));
                if (o_res.popped_value !== want.popped_value)
                    report_mismatch($sformatf("popped_value got %0d want %0d",
                                              o_res.popped_value, want.popped_value));
                if (o_res.depth !== want.depth)
                    report_mismatch($sformatf("depth got %0d want %0d",
                                              o_res.depth, want.depth));
                if (o_res.capacity !== want.capacity)
                    report_mismatch($sformatf("capacity got %0d want %0d",
                                              o_res.capacity, want.capacity));
                if (o_res.largest_capacity !== want.largest_capacity)
                    report_mismatch($sformatf("largest_capacity got %0d want %0d",
                                              o_res.largest_capacity,
                                              want.largest_capacity));
            end
        end
    end

    // Watchdog: too long without any handshake or result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || (i_cfg_valid && o_cfg_ready) || o_res_valid) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("resizing_stack_engine_core: mismatch");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        // Directed: empty pop, word extremes, growth, floor change while
        // holding entries, shrink down to a capacity of 5, empty pop again
        queue_cfg('0);
        queue_req(CMD_POP, 32'sd0, 17);
        queue_req(CMD_PUSH, 32'sh8000_0000, 17);
        queue_req(CMD_PUSH, 32'sh7FFF_FFFF, 17);
        queue_req(CMD_PUSH, 32'sd0, 17);
        queue_req(CMD_PUSH, -32'sd1, 17);
        queue_req(CMD_PUSH, 32'sh5555_5555, 17);
        queue_req(CMD_PUSH, 32'shAAAA_AAAA, 17);
        for (int k = 1; k <= 6; k++) queue_req(CMD_PUSH, k, 17);
        queue_cfg('1);
        for (int k = 0; k < 6; k++) queue_req(CMD_POP, $urandom, 17);
        queue_cfg(CNT_W'(MIN_CAP_FLOOR));
        for (int k = 0; k < 6; k++) queue_req(CMD_POP, $urandom, 17);
        queue_req(CMD_POP, 32'sd0, 17);

        // Small floor: grow then drain back to empty
        queue_cfg(CNT_W'($urandom_range(0, 40)));
        queue_random_run(120, 20, 17);
        queue_random_run(130, 85, 17);

        // Largest floor, fill to the storage limit, then drain partway
        queue_cfg('1);
        queue_random_run(1100, 2, 63);
        queue_cfg(CNT_W'($urandom_range(0, 2047)));
        queue_random_run(250, 92, 63);

        // Floor below the minimum, back-to-back traffic
        queue_cfg('0);
        queue_random_run(150, 50, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || start || i_cfg_valid ||
               pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && pending_results.size() == 0) begin
            $display("resizing_stack_engine_core: match");
        end else begin
            $display("resizing_stack_engine_core: mismatch");
        end
        $finish;
    end

endmodule
